// File: hw/rtl/ccrl_pkg.sv
// shared types, constants and sine table builder for the costas carrier recovery loop
// no dependencies
package ccrl_pkg;

  localparam int TRIG_FRAC = 15;
  localparam int TRIG_MAX = 32767;
  localparam int TRIG_W = 17;
  localparam int INTEG_BITS = 48;
  localparam int PROP_SHIFT = 8;
  localparam int GAIN_W = 32;
  localparam int CNT_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [CNT_W-1:0] ACQ_LEN_RESET = 16'd1000;
  localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACQ_PROP   = 3'd0,
    REG_ACQ_INT    = 3'd1,
    REG_TRACK_PROP = 3'd2,
    REG_TRACK_INT  = 3'd3,
    REG_QPSK_MODE  = 3'd4,
    REG_ACQ_LEN    = 3'd5
  } ccrl_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROT,
    ST_GAIN,
    ST_UPD
  } ccrl_state_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic mul;
    logic rot;
    logic gain;
    logic upd;
  } ccrl_cmd_t;

  function automatic logic [63:0] taylor_div(logic [63:0] v, int n);
    logic [63:0] r;
    r = v;
    unique case (n)
      1: r = v / 64'd6;
      2: r = v / 64'd20;
      3: r = v / 64'd42;
      4: r = v / 64'd72;
      5: r = v / 64'd110;
      6: r = v / 64'd156;
      default: r = v / 64'd210;
    endcase
    return r;
  endfunction

  // quarter-wave sine entry, taylor series to x^15 in q30, scaled to 32767
  function automatic logic [15:0] sine_entry(int k, int tb);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] scaled;
    longint sum;
    x = (64'(k) * HALF_PI_Q30) >> (tb - 2);
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = taylor_div(term, n);
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
    scaled = (64'(sum) * 64'(TRIG_MAX) + (64'd1 << 29)) >> 30;
    return scaled[15:0];
  endfunction

endpackage

// File: hw/rtl/ccrl_if.sv
// valid/ready stream interfaces for samples in and rotated samples out
// no dependencies
interface ccrl_in_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] in_i;
  logic signed [SAMPLE_BITS-1:0] in_q;
  logic                          block_start;

  modport source (output valid, in_i, in_q, block_start, input ready);
  modport sink (input valid, in_i, in_q, block_start, output ready);
endinterface

interface ccrl_out_if #(
  parameter int SAMPLE_BITS = 16
) ();
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] out_i;
  logic signed [SAMPLE_BITS:0] out_q;

  modport source (output valid, out_i, out_q, input ready);
  modport sink (input valid, out_i, out_q, output ready);
endinterface

// File: hw/rtl/ccrl_ctrl.sv
// sequencing state machine and output valid flag
// depends on ccrl_pkg
module ccrl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccrl_pkg::ccrl_cmd_t cmd_o
);

  ccrl_pkg::ccrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ccrl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    load_out   = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ccrl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = ccrl_pkg::ST_MUL;
      end
      ccrl_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ccrl_pkg::ST_ROT;
      end
      ccrl_pkg::ST_ROT: begin
        cmd_o.rot = 1'b1;
        state_d   = ccrl_pkg::ST_GAIN;
      end
      ccrl_pkg::ST_GAIN: begin
        // hold here until the output slot is free
        if (!out_valid_q || out_ready_i) begin
          load_out   = 1'b1;
          cmd_o.gain = 1'b1;
          state_d    = ccrl_pkg::ST_UPD;
        end
      end
      default: begin
        // phase update; the next sample may be taken in the same cycle
        cmd_o.upd  = 1'b1;
        in_ready_o = 1'b1;
        state_d    = in_valid_i ? ccrl_pkg::ST_MUL : ccrl_pkg::ST_IDLE;
      end
    endcase
    cmd_o.load_in = in_ready_o && in_valid_i;
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/ccrl_dp.sv
// datapath: nco lookup, complex rotation, discriminator and loop filter
// depends on ccrl_pkg
module ccrl_dp #(
  parameter int SAMPLE_BITS = 16,
  parameter int PHASE_BITS = 32,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ccrl_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [ccrl_pkg::GAIN_W-1:0]           cfg_data_i,
  input  ccrl_pkg::ccrl_cmd_t                   cmd_i,
  input  logic signed [SAMPLE_BITS-1:0]         in_i_i,
  input  logic signed [SAMPLE_BITS-1:0]         in_q_i,
  input  logic                                  block_start_i,
  output logic signed [SAMPLE_BITS:0]           out_i_o,
  output logic signed [SAMPLE_BITS:0]           out_q_o
);

  localparam int Quarter = 1 << (TRIG_TABLE_BITS - 2);
  localparam int TW = ccrl_pkg::TRIG_W;
  localparam int PW = SAMPLE_BITS + TW;
  localparam int SW = PW + 2;
  localparam int OW = SAMPLE_BITS + 1;
  localparam int DW = SAMPLE_BITS + 3;
  localparam int GW = ccrl_pkg::GAIN_W;
  localparam int IB = ccrl_pkg::INTEG_BITS;
  localparam int MW = DW + GW;
  localparam int AW = ((MW > IB) ? MW : IB) + 1;
  localparam int FW = ((MW + ccrl_pkg::PROP_SHIFT > IB) ? MW + ccrl_pkg::PROP_SHIFT : IB) + 1;
  localparam logic signed [SW-1:0] Rnd = SW'(1 << (ccrl_pkg::TRIG_FRAC - 1));
  localparam logic signed [IB-1:0] IMax = {1'b0, {(IB-1){1'b1}}};
  localparam logic signed [IB-1:0] IMin = {1'b1, {(IB-1){1'b0}}};

  // quarter-wave table, built at elaboration
  logic [15:0] sine_tab [Quarter+1];
  for (genvar k = 0; k <= Quarter; k++) begin : g_tab
    localparam logic [15:0] Entry = ccrl_pkg::sine_entry(k, TRIG_TABLE_BITS);
    assign sine_tab[k] = Entry;
  end

  // configuration
  logic signed [GW-1:0] acq_prop_q, acq_int_q, trk_prop_q, trk_int_q;
  logic                 qpsk_q;
  logic [ccrl_pkg::CNT_W-1:0] acq_len_q;

  // loop state
  logic [PHASE_BITS-1:0]      phase_q;
  logic signed [IB-1:0]       integ_q;
  logic [ccrl_pkg::CNT_W-1:0] cnt_q;

  // payload registers
  logic signed [SAMPLE_BITS-1:0] xi_q, xq_q;
  logic signed [PW-1:0] p_ic_q, p_qs_q, p_is_q, p_qc_q;
  logic signed [OW-1:0] oi_q, oq_q, out_i_q, out_q_q;
  logic signed [MW-1:0] pp_q, pi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acq_prop_q <= '0;
      acq_int_q  <= '0;
      trk_prop_q <= '0;
      trk_int_q  <= '0;
      qpsk_q     <= 1'b1;
      acq_len_q  <= ccrl_pkg::ACQ_LEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ccrl_pkg::REG_ACQ_PROP:   acq_prop_q <= cfg_data_i;
        ccrl_pkg::REG_ACQ_INT:    acq_int_q  <= cfg_data_i;
        ccrl_pkg::REG_TRACK_PROP: trk_prop_q <= cfg_data_i;
        ccrl_pkg::REG_TRACK_INT:  trk_int_q  <= cfg_data_i;
        ccrl_pkg::REG_QPSK_MODE:  qpsk_q     <= cfg_data_i[0];
        ccrl_pkg::REG_ACQ_LEN:    acq_len_q  <= cfg_data_i[ccrl_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // nco lookup with quadrant symmetry
  logic [TRIG_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [TRIG_TABLE_BITS-2:0] ra, rb;
  logic signed [TW-1:0]       a_w, b_w, cos_w, sin_w;

  always_comb begin
    idx  = phase_q[PHASE_BITS-1 -: TRIG_TABLE_BITS];
    quad = idx[TRIG_TABLE_BITS-1 -: 2];
    ra   = {1'b0, idx[TRIG_TABLE_BITS-3:0]};
    rb   = (TRIG_TABLE_BITS-1)'(Quarter) - ra;
    a_w  = TW'(sine_tab[ra]);
    b_w  = TW'(sine_tab[rb]);
    unique case (quad)
      2'd0: begin sin_w = a_w;  cos_w = b_w;  end
      2'd1: begin sin_w = b_w;  cos_w = -a_w; end
      2'd2: begin sin_w = -a_w; cos_w = -b_w; end
      default: begin sin_w = -b_w; cos_w = a_w; end
    endcase
  end

  // rotation sums, rounded half up
  logic signed [SW-1:0] sum_i, sum_q, sh_i, sh_q;
  always_comb begin
    sum_i = SW'(p_ic_q) - SW'(p_qs_q) + Rnd;
    sum_q = SW'(p_is_q) + SW'(p_qc_q) + Rnd;
    sh_i  = sum_i >>> ccrl_pkg::TRIG_FRAC;
    sh_q  = sum_q >>> ccrl_pkg::TRIG_FRAC;
  end

  // hard-decision discriminator and gain selection
  logic signed [DW-1:0] oi_x, oq_x, d_w;
  logic signed [GW-1:0] pg_w, ig_w;
  logic                 acq_sel;
  always_comb begin
    oi_x = DW'(oi_q);
    oq_x = DW'(oq_q);
    d_w  = oi_q[OW-1] ? -oq_x : oq_x;
    if (qpsk_q) begin
      d_w = oq_q[OW-1] ? d_w + oi_x : d_w - oi_x;
    end
    acq_sel = cnt_q < acq_len_q;
    pg_w    = acq_sel ? acq_prop_q : trk_prop_q;
    ig_w    = acq_sel ? acq_int_q : trk_int_q;
  end

  // saturating integrator and phase step
  logic signed [AW-1:0] acc;
  logic [AW-IB:0]       acc_top;
  logic signed [IB-1:0] integ_d;
  logic signed [FW-1:0] f_w;
  always_comb begin
    acc     = AW'(integ_q) + AW'(pi_q);
    acc_top = acc[AW-1:IB-1];
    if ((&acc_top) || !(|acc_top)) begin
      integ_d = acc[IB-1:0];
    end else begin
      integ_d = acc[AW-1] ? IMin : IMax;
    end
    f_w = (FW'(pp_q) <<< ccrl_pkg::PROP_SHIFT) + FW'(integ_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      integ_q <= '0;
      cnt_q   <= '0;
    end else begin
      // a block start on the next sample wins over the count of the one ending
      if (cmd_i.load_in && block_start_i) begin
        cnt_q <= '0;
      end else if (cmd_i.upd && (cnt_q != ccrl_pkg::CNT_MAX)) begin
        cnt_q <= cnt_q + ccrl_pkg::CNT_W'(1);
      end
      if (cmd_i.upd) begin
        integ_q <= integ_d;
        phase_q <= phase_q + f_w[IB-PHASE_BITS +: PHASE_BITS];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      xi_q <= in_i_i;
      xq_q <= in_q_i;
    end
    if (cmd_i.mul) begin
      p_ic_q <= PW'(xi_q) * PW'(cos_w);
      p_qs_q <= PW'(xq_q) * PW'(sin_w);
      p_is_q <= PW'(xi_q) * PW'(sin_w);
      p_qc_q <= PW'(xq_q) * PW'(cos_w);
    end
    if (cmd_i.rot) begin
      oi_q <= sh_i[OW-1:0];
      oq_q <= sh_q[OW-1:0];
    end
    if (cmd_i.gain) begin
      out_i_q <= oi_q;
      out_q_q <= oq_q;
      pp_q    <= MW'(d_w) * MW'(pg_w);
      pi_q    <= MW'(d_w) * MW'(ig_w);
    end
  end

  assign out_i_o = out_i_q;
  assign out_q_o = out_q_q;

endmodule

// File: hw/rtl/costas_carrier_recovery_loop.sv
// result path: mul, rot and gain states after the sample transfer; gain waits on a stall
// intake: a new sample is taken only as the phase feedback loop closes: nco lookup and
//   rotation multiply, rounding, discriminator and gain multiply, integrator and phase add
// reset: asynchronous active low; clears phase, integrator, block count and output valid,
//   gains to zero, qpsk mode on, acquisition length 1000
// depends on ccrl_pkg, ccrl_if, ccrl_ctrl, ccrl_dp
module costas_carrier_recovery_loop #(
  parameter int SAMPLE_BITS = 16,
  parameter int PHASE_BITS = 32,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // register write port
  input  logic                           cfg_we_i,
  input  logic [ccrl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ccrl_pkg::GAIN_W-1:0]    cfg_data_i,
  // sample streams
  ccrl_in_if.sink                        in_s,
  ccrl_out_if.source                     out_s
);

  ccrl_pkg::ccrl_cmd_t cmd;

  // controller: sequencing and output handshake
  ccrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_s.ready),
    .out_valid_o (out_s.valid),
    .out_ready_i (out_s.ready),
    .cmd_o       (cmd)
  );

  // datapath: nco, rotator, discriminator, loop filter
  ccrl_dp #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .PHASE_BITS      (PHASE_BITS),
    .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .in_i_i        (in_s.in_i),
    .in_q_i        (in_s.in_q),
    .block_start_i (in_s.block_start),
    .out_i_o       (out_s.out_i),
    .out_q_o       (out_s.out_q)
  );

endmodule

// File: tb/tb.sv
// self-checking testbench for the costas carrier recovery loop
// depends on ccrl_pkg, ccrl_if and costas_carrier_recovery_loop
`timescale 1ns / 100ps

module tb;

  localparam int PERIOD = 8;
  localparam int QUARTER = 256;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PER_PHASE = 125;
  // indexes past the register list, the block must ignore writes to them
  localparam logic [ccrl_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [ccrl_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic signed [15:0] si;
    logic signed [15:0] sq;
    logic               start;
  } sample_t;

  typedef struct packed {
    logic signed [16:0] ri;
    logic signed [16:0] rq;
  } rotated_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [ccrl_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [ccrl_pkg::GAIN_W-1:0]    cfg_data_i;

  ccrl_in_if #(.SAMPLE_BITS(16))  in_s ();
  ccrl_out_if #(.SAMPLE_BITS(16)) out_s ();

  costas_carrier_recovery_loop dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_s      (in_s),
    .out_s     (out_s)
  );

  // shadow of the register file
  logic [31:0] acq_prop, acq_int, trk_prop, trk_int;
  logic        qpsk;
  logic [15:0] acq_len;

  // loop state mirrored in the predictor
  logic [31:0]        phase_acc;
  logic signed [47:0] freq_int;
  logic [15:0]        blk_count;
  logic [15:0]        sine_q[QUARTER+1];

  sample_t  pending_samples[$];
  rotated_t expected_rot[$];

  int  send_idle, recv_idle;
  int  mismatches;
  int  cycles;
  bit  in_took;

  initial begin
    clk_i = 1'b0;
    forever #(PERIOD / 2) clk_i = ~clk_i;
  end

  // quarter-wave sine, taylor series to x^15 in q30, rounded to 32767 full scale
  function automatic void build_sine();
    logic [63:0] x, term;
    longint acc;
    for (int k = 0; k <= QUARTER; k++) begin
      x = (64'(k) * ccrl_pkg::HALF_PI_Q30) >> 8;
      term = x;
      acc = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        acc = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
      sine_q[k] = 16'((64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30);
    end
  endfunction

  // one loop step: rotate by the current phase, then advance the nco
  function automatic rotated_t rotate_and_advance(sample_t smp);
    logic [9:0] idx;
    longint xi, xq, a, b, c, s, oi, oq, d, pg, ig, acc, f;
    rotated_t r;
    xi = longint'(smp.si);
    xq = longint'(smp.sq);
    if (smp.start) blk_count = '0;
    idx = phase_acc[31:22];
    a = longint'(sine_q[idx[7:0]]);
    b = longint'(sine_q[QUARTER - int'(idx[7:0])]);
    case (idx[9:8])
      2'd0: begin s = a; c = b; end
      2'd1: begin s = b; c = -a; end
      2'd2: begin s = -a; c = -b; end
      default: begin s = -b; c = a; end
    endcase
    oi = (xi * c - xq * s + 16384) >>> 15;
    oq = (xi * s + xq * c + 16384) >>> 15;
    r.ri = 17'(oi);
    r.rq = 17'(oq);
    // hard-decision discriminator, a zero component counts as positive
    d = (oi >= 0) ? oq : -oq;
    if (qpsk) d = d - ((oq >= 0) ? oi : -oi);
    if (blk_count < acq_len) begin
      pg = longint'(signed'(acq_prop));
      ig = longint'(signed'(acq_int));
    end else begin
      pg = longint'(signed'(trk_prop));
      ig = longint'(signed'(trk_int));
    end
    acc = longint'(freq_int) + d * ig;
    if (acc > (longint'(1) << 47) - 1) acc = (longint'(1) << 47) - 1;
    if (acc < -(longint'(1) << 47)) acc = -(longint'(1) << 47);
    freq_int = 48'(acc);
    f = d * pg * 256 + acc;
    phase_acc = phase_acc + 32'(f >>> 16);
    if (blk_count != 16'hFFFF) blk_count = blk_count + 16'd1;
    return r;
  endfunction

  task automatic write_reg(logic [ccrl_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      ccrl_pkg::REG_ACQ_PROP:   acq_prop = data;
      ccrl_pkg::REG_ACQ_INT:    acq_int = data;
      ccrl_pkg::REG_TRACK_PROP: trk_prop = data;
      ccrl_pkg::REG_TRACK_INT:  trk_int = data;
      ccrl_pkg::REG_QPSK_MODE:  qpsk = data[0];
      ccrl_pkg::REG_ACQ_LEN:    acq_len = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_config(logic [31:0] ap, logic [31:0] ai, logic [31:0] tp,
                             logic [31:0] ti, logic [31:0] mode, logic [31:0] len);
    write_reg(ccrl_pkg::REG_ACQ_PROP, ap);
    write_reg(ccrl_pkg::REG_ACQ_INT, ai);
    write_reg(ccrl_pkg::REG_TRACK_PROP, tp);
    write_reg(ccrl_pkg::REG_TRACK_INT, ti);
    write_reg(ccrl_pkg::REG_QPSK_MODE, mode);
    write_reg(ccrl_pkg::REG_ACQ_LEN, len);
  endtask

  // block is idle once every result is back plus the pipeline latency
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_s.valid || expected_rot.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] small_gain();
    return 32'($signed($urandom_range(0, 8192)) - 4096);
  endfunction

  function automatic sample_t random_sample();
    sample_t smp;
    smp.start = ($urandom_range(15) == 0);
    case ($urandom_range(7))
      0: begin
        smp.si = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        smp.sq = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      end
      1: begin
        smp.si = 16'($signed($urandom_range(0, 64)) - 32);
        smp.sq = 16'($signed($urandom_range(0, 64)) - 32);
      end
      default: begin
        smp.si = 16'($urandom);
        smp.sq = 16'($urandom);
      end
    endcase
    return smp;
  endfunction

  task automatic queue_random(int n);
    repeat (n) pending_samples.push_back(random_sample());
  endtask

  // driver: at the falling edge after the last transfer a new sample goes out, or the sender idles
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_s.valid || in_took) begin
        in_took = 1'b0;
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle) begin
          sample_t smp;
          smp = pending_samples.pop_front();
          in_s.valid <= 1'b1;
          in_s.in_i <= smp.si;
          in_s.in_q <= smp.sq;
          in_s.block_start <= smp.start;
        end else begin
          in_s.valid <= 1'b0;
        end
      end
      out_s.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor: predict on every input transfer, check every output transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_s.valid && in_s.ready) begin
        sample_t smp;
        smp.si = in_s.in_i;
        smp.sq = in_s.in_q;
        smp.start = in_s.block_start;
        expected_rot.push_back(rotate_and_advance(smp));
        in_took = 1'b1;
      end
      if (out_s.valid && out_s.ready) begin
        rotated_t want;
        if (expected_rot.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result i=%0d q=%0d", out_s.out_i, out_s.out_q);
        end else begin
          want = expected_rot.pop_front();
          if (out_s.out_i !== want.ri || out_s.out_q !== want.rq) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected i=%0d q=%0d, got i=%0d q=%0d",
                       want.ri, want.rq, out_s.out_i, out_s.out_q);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    sample_t smp;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ccrl_pkg::REG_ACQ_PROP;
    cfg_data_i = '0;
    in_s.valid = 1'b0;
    in_s.in_i = '0;
    in_s.in_q = '0;
    in_s.block_start = 1'b0;
    out_s.ready = 1'b0;
    mismatches = 0;
    cycles = 0;
    in_took = 1'b0;
    send_idle = 35;
    recv_idle = 57;
    build_sine();
    acq_prop = '0; acq_int = '0; trk_prop = '0; trk_int = '0;
    qpsk = 1'b1;
    acq_len = ccrl_pkg::ACQ_LEN_RESET;
    phase_acc = '0;
    freq_int = '0;
    blk_count = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, zero sample, block restarts with a short
    // acquisition window, and ignored / masked register writes
    load_config(32'h0000_4000, 32'h0010_0000, 32'hFFFF_E000, 32'hF800_0000,
                32'hFFFF_FFFF, 32'h0001_0003);
    write_reg(IDX_SPARE_LO, 32'hDEAD_BEEF);
    write_reg(IDX_SPARE_HI, 32'h1234_5678);
    pending_samples.push_back('{16'sd0, 16'sd0, 1'b1});
    pending_samples.push_back('{16'sh7FFF, 16'sh7FFF, 1'b0});
    pending_samples.push_back('{16'sh8000, 16'sh8000, 1'b0});
    pending_samples.push_back('{16'sh7FFF, 16'sh8000, 1'b0});
    pending_samples.push_back('{16'sh8000, 16'sh7FFF, 1'b0});
    pending_samples.push_back('{16'sd0, -16'sd1, 1'b0});
    pending_samples.push_back('{-16'sd1, 16'sd0, 1'b1});
    pending_samples.push_back('{16'sd1, 16'sd1, 1'b0});
    pending_samples.push_back('{16'sh5555, 16'shAAAA, 1'b0});
    pending_samples.push_back('{16'shAAAA, 16'sh5555, 1'b0});
    pending_samples.push_back('{16'sd12000, -16'sd9000, 1'b1});
    pending_samples.push_back('{16'sd0, 16'sh7FFF, 1'b0});
    wait_idle();
    // bpsk discriminator, masked mode write, then saturating gains
    load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'hFFFF_FFFE, 32'd2);
    pending_samples.push_back('{16'sh7FFF, 16'sd0, 1'b1});
    for (int k = 0; k < 9; k++) begin
      smp.si = (k % 2) ? 16'sh8000 : 16'sh7FFF;
      smp.sq = (k % 3) ? 16'sh7FFF : 16'sh8000;
      smp.start = (k == 5);
      pending_samples.push_back(smp);
    end
    wait_idle();

    // random phases: sender idles 35, receiver 57
    load_config(small_gain(), small_gain(), small_gain(), small_gain(), 32'd0, 32'd0);
    queue_random(RAND_PER_PHASE);
    wait_idle();
    load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'd1, 32'd65535);
    queue_random(RAND_PER_PHASE);
    wait_idle();

    // the other way round
    send_idle = 57;
    recv_idle = 35;
    load_config($urandom, $urandom, $urandom, $urandom, 32'd0, $urandom_range(0, 40));
    queue_random(RAND_PER_PHASE);
    wait_idle();
    load_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'd1, 32'd1);
    queue_random(RAND_PER_PHASE);
    wait_idle();

    // no idling on either side
    send_idle = 0;
    recv_idle = 0;
    load_config(small_gain(), small_gain(), small_gain(), small_gain(), 32'd1, 32'd20);
    queue_random(RAND_PER_PHASE);
    wait_idle();
    load_config(small_gain(), $urandom, small_gain(), $urandom, 32'd0,
                $urandom_range(0, 65535));
    queue_random(RAND_PER_PHASE);
    wait_idle();

    if (mismatches == 0 && expected_rot.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ccrl_pkg.sv
hw/rtl/ccrl_if.sv
hw/rtl/ccrl_ctrl.sv
hw/rtl/ccrl_dp.sv
hw/rtl/costas_carrier_recovery_loop.sv
tb/tb.sv
